// ===== src/ert_pkg.sv =====
// ============================================================================
// ert_pkg: shared types and constants for the epoch reclamation tracker
// Command and result words, action and result codes, and derived sizes.
// ============================================================================
package ert_pkg;

    localparam int THREAD_SLOTS  = 16;
    localparam int EPOCH_BUCKETS = 3;
    localparam int BUCKET_DEPTH  = 16;

    localparam int EPOCH_W   = 64;
    localparam int SLOT_IW   = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int IDX_W     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
    localparam int RAM_DEPTH = EPOCH_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    // action codes
    localparam logic [2:0] ACT_REGISTER   = 3'd0;
    localparam logic [2:0] ACT_UNREGISTER = 3'd1;
    localparam logic [2:0] ACT_ENTER      = 3'd2;
    localparam logic [2:0] ACT_EXIT       = 3'd3;
    localparam logic [2:0] ACT_RETIRE     = 3'd4;
    localparam logic [2:0] ACT_ADVANCE    = 3'd5;
    // spare codes: ignored, no result
    localparam logic [2:0] ACT_RSVD6      = 3'd6;
    localparam logic [2:0] ACT_RSVD7      = 3'd7;

    // result kinds
    localparam logic [1:0] KIND_GRANT   = 2'd0;
    localparam logic [1:0] KIND_NO_SLOT = 2'd1;
    localparam logic [1:0] KIND_EPOCH   = 2'd2;
    localparam logic [1:0] KIND_FREE    = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         slot;
        logic [EPOCH_W-1:0] pointer;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         granted_slot;
        logic [EPOCH_W-1:0] epoch_value;
        logic [EPOCH_W-1:0] free_pointer;
        logic               last;
    } result_t;

    typedef struct packed {
        logic               set_active;
        logic               clr_active;
        logic               wr_epoch;
        logic [SLOT_IW-1:0] wr_idx;
        logic [EPOCH_W-1:0] wr_value;
        logic [SLOT_IW-1:0] rd_idx;
    } slot_ctl_t;

    typedef struct packed {
        logic active;
        logic lag;
    } slot_sts_t;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [EPOCH_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } ram_ctl_t;

endpackage

// ===== src/ert_slot_table.sv =====
// ============================================================================
// ert_slot_table: per-thread slot state and the shared lag comparator
// Holds active bits and recorded epochs; one slot is examined per cycle.
// ============================================================================
module ert_slot_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ert_pkg::slot_ctl_t             ctl,
    input  logic [ert_pkg::EPOCH_W-1:0]    cur_epoch,
    output ert_pkg::slot_sts_t             sts
);
    import ert_pkg::*;

    logic [THREAD_SLOTS-1:0] active_reg;
    logic [EPOCH_W-1:0]      epoch_reg [THREAD_SLOTS];
    logic [EPOCH_W-1:0]      rd_epoch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                epoch_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.set_active)
            begin
                active_reg[ctl.wr_idx] <= 1'b1;
            end
            if (ctl.clr_active)
            begin
                active_reg[ctl.wr_idx] <= 1'b0;
            end
            if (ctl.wr_epoch)
            begin
                epoch_reg[ctl.wr_idx] <= ctl.wr_value;
            end
        end
    end

    // exited slots carry the all-ones mark and never lag
    assign rd_epoch   = epoch_reg[ctl.rd_idx];
    assign sts.active = active_reg[ctl.rd_idx];
    assign sts.lag    = active_reg[ctl.rd_idx] && (rd_epoch != EPOCH_MAX)
                        && (rd_epoch < cur_epoch);

endmodule

// ===== src/ert_bucket_store.sv =====
// ============================================================================
// ert_bucket_store: retired pointer storage for all three buckets
// One write port, one registered read port.
// ============================================================================
module ert_bucket_store (
    input  logic                        clk,
    input  ert_pkg::ram_ctl_t           ctl,
    output logic [ert_pkg::EPOCH_W-1:0] rd_data
);
    import ert_pkg::*;

    logic [EPOCH_W-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[ctl.rd_addr];
        end
    end

endmodule

// ===== src/epoch_reclamation_tracker_top.sv =====
// ============================================================================
// epoch_reclamation_tracker_top: three-epoch reclamation tracker
// Slot registration, epoch entry/exit, pointer retirement and epoch advance.
// ============================================================================
// A command word is taken when start is high and busy is low. Unregister,
// exit and retire finish in the accept cycle, so busy stays low and a new
// word may follow at once. Register scans the slots one per cycle for the
// lowest free one. Enter and try advance run the lag check over all slots
// through one 64-bit comparator, one slot per cycle, stopping early if a
// lagging slot is found; an advance then drains the released bucket newest
// first, one pointer per cycle through the bucket memory read port.
// Results leave through an output register in the cycle after they are
// formed, each for exactly one cycle with strobe high; the receiver cannot
// stall, so it must take every word in the cycle it appears. last marks the
// final result word of a command. No clearing pass follows reset.
module epoch_reclamation_tracker_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ert_pkg::cmd_t    request,
    output logic             busy,
    output logic             strobe,
    output ert_pkg::result_t result
);
    import ert_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FREE, S_LAG, S_DRAIN} state_t;

    localparam logic [SLOT_IW-1:0] LAST_SLOT = SLOT_IW'(THREAD_SLOTS - 1);
    localparam logic [FILL_W-1:0]  FULL     = FILL_W'(BUCKET_DEPTH);

    state_t              state_reg,      state_next;
    logic                enter_reg,      enter_next;
    logic [SLOT_IW-1:0]  scan_reg,       scan_next;
    logic [EPOCH_W-1:0]  epoch_reg,      epoch_next;
    logic [1:0]          phase_reg,      phase_next;     // epoch mod 3
    logic [1:0]          rel_bucket_reg, rel_bucket_next;
    logic [IDX_W-1:0]    rd_idx_reg,     rd_idx_next;
    logic [FILL_W-1:0]   fill_reg [EPOCH_BUCKETS];
    logic [FILL_W-1:0]   fill_next [EPOCH_BUCKETS];
    logic                strobe_reg,     strobe_next;
    result_t             result_reg,     result_next;

    slot_ctl_t           slot_ctl;
    slot_sts_t           slot_sts;
    ram_ctl_t            ram_ctl;
    logic [EPOCH_W-1:0]  ram_rd_data;

    logic                slot_ok;
    logic [1:0]          rel_b;
    logic [FILL_W-1:0]   rel_n;

    function automatic logic [ADDR_W-1:0] bucket_addr(input logic [1:0] b,
                                                      input logic [IDX_W-1:0] idx);
        bucket_addr = ADDR_W'(b) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(idx);
    endfunction

    // bucket of (epoch - 1) mod 3
    function automatic logic [1:0] prev_phase(input logic [1:0] p);
        case (p)
            2'd0:    prev_phase = 2'd2;
            2'd1:    prev_phase = 2'd0;
            2'd2:    prev_phase = 2'd1;
            default: prev_phase = 2'd0;
        endcase
    endfunction

    ert_slot_table u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (slot_ctl),
        .cur_epoch    (epoch_reg),
        .sts          (slot_sts)
    );

    ert_bucket_store u_store (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_data (ram_rd_data)
    );

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign result  = result_reg;
    assign slot_ok = (32'(request.slot) < THREAD_SLOTS);
    assign rel_b   = prev_phase(phase_reg);
    assign rel_n   = fill_reg[rel_b];

    always_comb
    begin
        state_next      = state_reg;
        enter_next      = enter_reg;
        scan_next       = scan_reg;
        epoch_next      = epoch_reg;
        phase_next      = phase_reg;
        rel_bucket_next = rel_bucket_reg;
        rd_idx_next     = rd_idx_reg;
        for (int i = 0; i < EPOCH_BUCKETS; i++)
        begin
            fill_next[i] = fill_reg[i];
        end
        strobe_next = 1'b0;
        result_next = '0;
        slot_ctl    = '0;
        ram_ctl     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    slot_ctl.wr_idx = SLOT_IW'(request.slot);
                    case (request.action)
                        ACT_REGISTER:
                        begin
                            scan_next  = '0;
                            state_next = S_FREE;
                        end
                        ACT_UNREGISTER:
                        begin
                            slot_ctl.clr_active = slot_ok;
                        end
                        ACT_ENTER:
                        begin
                            slot_ctl.wr_epoch = slot_ok;
                            slot_ctl.wr_value = epoch_reg;
                            enter_next        = 1'b1;
                            scan_next         = '0;
                            state_next        = S_LAG;
                        end
                        ACT_EXIT:
                        begin
                            slot_ctl.wr_epoch = slot_ok;
                            slot_ctl.wr_value = EPOCH_MAX;
                        end
                        ACT_RETIRE:
                        begin
                            if (fill_reg[phase_reg] >= FULL)
                            begin
                                // bucket full: hand the pointer straight back
                                strobe_next              = 1'b1;
                                result_next.kind         = KIND_FREE;
                                result_next.free_pointer = request.pointer;
                                result_next.last         = 1'b1;
                            end
                            else
                            begin
                                ram_ctl.wr_en   = 1'b1;
                                ram_ctl.wr_addr = bucket_addr(phase_reg,
                                                              IDX_W'(fill_reg[phase_reg]));
                                ram_ctl.wr_data = request.pointer;
                                fill_next[phase_reg] = fill_reg[phase_reg] + FILL_W'(1);
                            end
                        end
                        ACT_ADVANCE:
                        begin
                            enter_next = 1'b0;
                            scan_next  = '0;
                            state_next = S_LAG;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FREE:
            begin
                slot_ctl.rd_idx = scan_reg;
                if (!slot_sts.active)
                begin
                    slot_ctl.set_active      = 1'b1;
                    slot_ctl.wr_epoch        = 1'b1;
                    slot_ctl.wr_idx          = scan_reg;
                    slot_ctl.wr_value        = epoch_reg;
                    strobe_next              = 1'b1;
                    result_next.kind         = KIND_GRANT;
                    result_next.granted_slot = 4'(scan_reg);
                    result_next.last         = 1'b1;
                    state_next               = S_IDLE;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    strobe_next      = 1'b1;
                    result_next.kind = KIND_NO_SLOT;
                    result_next.last = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + SLOT_IW'(1);
                end
            end

            S_LAG:
            begin
                slot_ctl.rd_idx = scan_reg;
                if (slot_sts.lag)
                begin
                    // no advance; enter still reports its epoch
                    strobe_next             = enter_reg;
                    result_next.kind        = KIND_EPOCH;
                    result_next.epoch_value = epoch_reg;
                    result_next.last        = 1'b1;
                    state_next              = S_IDLE;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    epoch_next = epoch_reg + EPOCH_W'(1);
                    // 2^64 - 1 is a multiple of 3, so the wrap keeps phase 0
                    if (epoch_reg == EPOCH_MAX)
                    begin
                        phase_next = 2'd0;
                    end
                    else
                    begin
                        phase_next = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                    end
                    fill_next[rel_b]        = '0;
                    rel_bucket_next         = rel_b;
                    strobe_next             = enter_reg;
                    result_next.kind        = KIND_EPOCH;
                    result_next.epoch_value = epoch_reg;
                    result_next.last        = (rel_n == '0);
                    if (rel_n != '0)
                    begin
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = bucket_addr(rel_b, IDX_W'(rel_n - FILL_W'(1)));
                        rd_idx_next     = IDX_W'(rel_n - FILL_W'(1));
                        state_next      = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + SLOT_IW'(1);
                end
            end

            S_DRAIN:
            begin
                strobe_next              = 1'b1;
                result_next.kind         = KIND_FREE;
                result_next.free_pointer = ram_rd_data;
                result_next.last         = (rd_idx_reg == '0);
                if (rd_idx_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_ctl.rd_en   = 1'b1;
                    ram_ctl.rd_addr = bucket_addr(rel_bucket_reg, rd_idx_reg - IDX_W'(1));
                    rd_idx_next     = rd_idx_reg - IDX_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            enter_reg  <= 1'b0;
            scan_reg   <= '0;
            epoch_reg  <= '0;
            phase_reg  <= 2'd0;
            rel_bucket_reg <= 2'd0;
            rd_idx_reg <= '0;
            for (int i = 0; i < EPOCH_BUCKETS; i++)
            begin
                fill_reg[i] <= '0;
            end
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            enter_reg  <= enter_next;
            scan_reg   <= scan_next;
            epoch_reg  <= epoch_next;
            phase_reg  <= phase_next;
            rel_bucket_reg <= rel_bucket_next;
            rd_idx_reg <= rd_idx_next;
            for (int i = 0; i < EPOCH_BUCKETS; i++)
            begin
                fill_reg[i] <= fill_next[i];
            end
            strobe_reg <= strobe_next;
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // a result word that is not the last one must have more behind it
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy)
        else $error("non-last result with sequencer idle");

    // unregister, exit and the spare codes leave the strobe low
    a_silent_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (request.action == ACT_UNREGISTER
            || request.action == ACT_EXIT || request.action == ACT_RSVD6
            || request.action == ACT_RSVD7) |=> !strobe)
        else $error("result from a silent command");

    // the epoch only moves at the end of a lag scan
    a_epoch_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(epoch_reg) |-> $past(state_reg == S_LAG))
        else $error("epoch changed outside lag scan");

    // bucket fills stay within depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[0] <= FULL && fill_reg[1] <= FULL && fill_reg[2] <= FULL)
        else $error("bucket fill over depth");

    // a grant only comes out of the free-slot search
    a_grant_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.kind == KIND_GRANT |-> $past(state_reg == S_FREE))
        else $error("slot grant outside search");
`endif

endmodule

// ===== bench/tb_epoch_reclamation_tracker_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_epoch_reclamation_tracker_top: self-checking bench for the epoch tracker
// Drives command words in random bursts, predicts every result word from a
// local model of slots, epoch and buckets, and checks results in order.
// ============================================================================
module tb_epoch_reclamation_tracker_top;

    import ert_pkg::*;

    localparam int SETTLE_CYCLES = 48;      // > worst case scan + drain of one command
    localparam int TIMEOUT_NS    = 500000;  // far above the slowest run
    localparam int MAX_PRINTS    = 40;

    logic    clk     = 1'b0;
    logic    rst_n   = 1'b0;
    logic    start   = 1'b0;
    cmd_t    request = '0;
    logic    busy;
    logic    strobe;
    result_t result;

    always #2 clk = ~clk;

    epoch_reclamation_tracker_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // ------------------------------------------------------------------------
    // Local tracker model: its own copy of the slot table, epoch and buckets.
    // Updated at the edge where a command word is taken; every result word it
    // predicts goes to pending_words in issue order.
    // ------------------------------------------------------------------------
    logic [EPOCH_W-1:0] glob_epoch = '0;
    logic [EPOCH_W-1:0] slot_stamp [THREAD_SLOTS] = '{default: '0};
    logic               slot_live  [THREAD_SLOTS] = '{default: 1'b0};
    // entries above a bucket's count are never read, so no reset is needed
    logic [EPOCH_W-1:0] bucket_mem [EPOCH_BUCKETS][BUCKET_DEPTH];
    int unsigned        bucket_cnt [EPOCH_BUCKETS] = '{default: 0};

    result_t pending_words [$];
    result_t release_words [$];   // scratch: pointers freed by one advance

    int mismatch_count = 0;

    // stimulus pacing
    int burst_left = 0;
    bit steady     = 1'b0;        // when set, the sender never idles

    // Lag check, then bump the epoch and release bucket (epoch-1) mod 3,
    // newest pointer first, last mark on the oldest.
    function automatic void predict_advance();
        logic [EPOCH_W-1:0] ge;
        int                 i;
        int                 b;
        int unsigned        n;
        result_t            w;
        ge = glob_epoch;
        for (i = 0; i < THREAD_SLOTS; i++)
        begin
            if (slot_live[i] && slot_stamp[i] != EPOCH_MAX && slot_stamp[i] < ge)
                return;
        end
        glob_epoch = ge + 1'b1;
        b = int'(((ge % EPOCH_BUCKETS) + EPOCH_BUCKETS - 1) % EPOCH_BUCKETS);
        n = bucket_cnt[b];
        while (n > 0)
        begin
            n--;
            w              = '0;
            w.kind         = KIND_FREE;
            w.free_pointer = bucket_mem[b][n];
            w.last         = (n == 0);
            release_words.push_back(w);
        end
        bucket_cnt[b] = 0;
    endfunction

    function automatic void predict_tracker_words(input cmd_t c);
        result_t            w;
        logic [EPOCH_W-1:0] ge;
        int                 i;
        int                 b;
        bit                 found;
        w      = '0;
        w.last = 1'b1;
        found  = 1'b0;
        release_words.delete();
        case (c.action)
            ACT_REGISTER:
            begin
                // lowest free slot wins
                for (i = 0; i < THREAD_SLOTS && !found; i++)
                begin
                    if (!slot_live[i])
                    begin
                        slot_live[i]   = 1'b1;
                        slot_stamp[i]  = glob_epoch;
                        w.kind         = KIND_GRANT;
                        w.granted_slot = 4'(i);
                        found          = 1'b1;
                    end
                end
                if (!found)
                    w.kind = KIND_NO_SLOT;
                pending_words.push_back(w);
            end
            ACT_UNREGISTER:
                slot_live[c.slot] = 1'b0;   // stamp is kept
            ACT_ENTER:
            begin
                ge                = glob_epoch;
                slot_stamp[c.slot] = ge;
                predict_advance();
                w.kind        = KIND_EPOCH;
                w.epoch_value = ge;
                w.last        = (release_words.size() == 0);
                pending_words.push_back(w);
                foreach (release_words[k])
                    pending_words.push_back(release_words[k]);
            end
            ACT_EXIT:
                slot_stamp[c.slot] = EPOCH_MAX;
            ACT_RETIRE:
            begin
                b = int'(glob_epoch % EPOCH_BUCKETS);
                if (bucket_cnt[b] >= BUCKET_DEPTH)
                begin
                    // full bucket: pointer comes straight back
                    w.kind         = KIND_FREE;
                    w.free_pointer = c.pointer;
                    pending_words.push_back(w);
                end
                else
                begin
                    bucket_mem[b][bucket_cnt[b]] = c.pointer;
                    bucket_cnt[b]++;
                end
            end
            ACT_ADVANCE:
            begin
                predict_advance();
                foreach (release_words[k])
                    pending_words.push_back(release_words[k]);
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Samples the pre-edge values of start/busy/request/strobe at
    // each rising edge, so nothing hinges on event order within the step.
    // The command is predicted before the result is checked, in case a word
    // ever appears at the very edge its command is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (start && !busy)
                predict_tracker_words(request);
            if (strobe)
            begin
                if (pending_words.size() == 0)
                    flag_mismatch($sformatf("unexpected result word kind %0d", result.kind));
                else
                begin
                    want = pending_words.pop_front();
                    if (result.kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d",
                                                result.kind, want.kind));
                    if (result.granted_slot !== want.granted_slot)
                        flag_mismatch($sformatf("granted_slot %0d, want %0d",
                                                result.granted_slot, want.granted_slot));
                    if (result.epoch_value !== want.epoch_value)
                        flag_mismatch($sformatf("epoch_value %h, want %h",
                                                result.epoch_value, want.epoch_value));
                    if (result.free_pointer !== want.free_pointer)
                        flag_mismatch($sformatf("free_pointer %h, want %h",
                                                result.free_pointer, want.free_pointer));
                    if (result.last !== want.last)
                        flag_mismatch($sformatf("last %b, want %b",
                                                result.last, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Words go out in bursts of random length; between bursts start
    // drops for a random gap, now and then long enough to span a full scan
    // and drain. Called right after a rising edge; returns at the edge where
    // the word was taken, with start still high.
    // ------------------------------------------------------------------------
    task automatic send_word(input cmd_t w);
        int gap;
        if (burst_left == 0)
        begin
            if (steady)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(20, 45);
            else
                gap = $urandom_range(0, 4);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start   <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
    endtask

    // Sender holds off until every predicted word is in and the block is
    // idle, then a little longer for anything stray.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic cmd_t make_word(input logic [2:0] act, input logic [3:0] slot,
                                       input logic [EPOCH_W-1:0] ptr);
        cmd_t c;
        c.action  = act;
        c.slot    = slot;
        c.pointer = ptr;
        return c;
    endfunction

    function automatic logic [EPOCH_W-1:0] rand_ptr();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Directed: every action, spare codes, field extremes, empty-bucket
    // advance, lag blocking an advance, exit sentinel, unregister keeping the
    // stamp, and a release of several pointers newest first.
    // ------------------------------------------------------------------------
    task automatic test_directed_ops();
        send_word(make_word(ACT_ADVANCE, 4'h0, '0));       // empty bucket, epoch 0 -> 1
        send_word(make_word(ACT_RSVD6, 4'hF, '1));
        send_word(make_word(ACT_RSVD7, 4'h0, '0));
        send_word(make_word(ACT_REGISTER, 4'hF, '1));      // slot 0
        send_word(make_word(ACT_REGISTER, 4'h0, '0));      // slot 1
        send_word(make_word(ACT_ENTER, 4'h0, rand_ptr())); // no lag, epoch 1 -> 2
        send_word(make_word(ACT_RETIRE, 4'h0, '1));
        send_word(make_word(ACT_RETIRE, 4'hF, '0));
        send_word(make_word(ACT_RETIRE, 4'h5, rand_ptr()));
        send_word(make_word(ACT_EXIT, 4'h1, '0));
        send_word(make_word(ACT_ADVANCE, 4'h0, '0));       // slot 0 lags: nothing
        send_word(make_word(ACT_ENTER, 4'h1, '0));         // epoch word only
        send_word(make_word(ACT_EXIT, 4'h0, '0));
        send_word(make_word(ACT_EXIT, 4'h1, '1));          // both on sentinel now
        send_word(make_word(ACT_ADVANCE, 4'hF, '1));       // releases an empty bucket
        send_word(make_word(ACT_ADVANCE, 4'h0, '0));       // releases the three retires
        send_word(make_word(ACT_UNREGISTER, 4'hF, '0));    // never registered
        send_word(make_word(ACT_UNREGISTER, 4'h1, '0));
        send_word(make_word(ACT_REGISTER, 4'h7, '0));      // slot 1 again
        send_word(make_word(ACT_ENTER, 4'hF, '0));         // inactive slot still reports
        send_word(make_word(ACT_REGISTER, 4'h0, '1));      // slot 2
    endtask

    // Fill every slot until one is refused, free a few, take them back.
    task automatic test_slot_exhaustion();
        int i;
        for (i = 0; i <= THREAD_SLOTS; i++)
            send_word(make_word(ACT_REGISTER, 4'($urandom), rand_ptr()));
        for (i = 0; i < 3; i++)
            send_word(make_word(ACT_UNREGISTER, 4'($urandom), rand_ptr()));
        for (i = 0; i < 4; i++)
            send_word(make_word(ACT_REGISTER, 4'($urandom), rand_ptr()));
    endtask

    // Overflow one bucket, release it whole, then refill one so that an enter
    // returns its epoch word plus a full bucket of pointers.
    task automatic test_bucket_overflow();
        int i;
        steady = 1'b1;
        for (i = 0; i < THREAD_SLOTS; i++)
            send_word(make_word(ACT_EXIT, 4'(i), rand_ptr()));
        for (i = 0; i < BUCKET_DEPTH + 2; i++)
            send_word(make_word(ACT_RETIRE, 4'($urandom), rand_ptr()));
        steady = 1'b0;
        drain_results();
        for (i = 0; i < 2; i++)
            send_word(make_word(ACT_ADVANCE, 4'($urandom), rand_ptr()));
        for (i = 0; i < BUCKET_DEPTH; i++)
            send_word(make_word(ACT_RETIRE, 4'($urandom), rand_ptr()));
        send_word(make_word(ACT_ADVANCE, 4'($urandom), rand_ptr()));
        send_word(make_word(ACT_ENTER, 4'($urandom), rand_ptr()));
    endtask

    // Random mix, weighted toward exits and retires so advances keep firing.
    task automatic test_random_traffic();
        int         i;
        int         r;
        logic [2:0] act;
        for (i = 0; i < 40; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                act = ACT_REGISTER;
            else if (r < 20)
                act = ACT_UNREGISTER;
            else if (r < 40)
                act = ACT_ENTER;
            else if (r < 60)
                act = ACT_EXIT;
            else if (r < 85)
                act = ACT_RETIRE;
            else if (r < 97)
                act = ACT_ADVANCE;
            else if (r < 99)
                act = ACT_RSVD6;
            else
                act = ACT_RSVD7;
            send_word(make_word(act, 4'($urandom), rand_ptr()));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_slot_exhaustion();
        test_bucket_overflow();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard: a lost word or a stuck busy ends here
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result words outstanding", pending_words.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ert_pkg.sv
src/ert_slot_table.sv
src/ert_bucket_store.sv
src/epoch_reclamation_tracker_top.sv
bench/tb_epoch_reclamation_tracker_top.sv
